// ===== rtl/htb_pkg.sv =====
// Shared types and constants for the hex text to bytes decoder.
`default_nettype none

package htb_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned TOTAL_BITS = 16;
  localparam int unsigned LIMIT_BITS = 16;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_LOW_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LOW_F  = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_F   = 8'h46;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FORMAT = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_NO_ROOM    = 2'd3
  } status_e;

  localparam logic [0:0] REG_BYTE_LIMIT = 1'b0;

  // Per-string decoder state
  typedef struct packed {
    logic                  pending_valid;
    logic [CHAR_BITS-1:0]  pending_char;
    logic [COUNT_BITS-1:0] bytes_done;
    status_e               error_code;
    logic                  stopped;
  } dec_state_t;

  // One result word
  typedef struct packed {
    logic [CHAR_BITS-1:0]  byte_value;
    logic                  byte_valid;
    logic                  done_res;
    status_e               status;
    logic [TOTAL_BITS-1:0] byte_total;
  } dec_result_t;

  localparam dec_state_t STATE_RESET = '{
    pending_valid: 1'b0,
    pending_char:  '0,
    bytes_done:    '0,
    error_code:    ST_OK,
    stopped:       1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/htb_step.sv =====
// Per-character decode step: next state and result for one input word.
`default_nettype none

module htb_step (
  input  htb_pkg::dec_state_t               state_i,
  input  logic [htb_pkg::CHAR_BITS-1:0]     char_i,
  input  logic                              last_i,
  input  logic [htb_pkg::LIMIT_BITS-1:0]    byte_limit_i,
  output htb_pkg::dec_state_t               state_o,
  output htb_pkg::dec_result_t              result_o,
  output logic                              emit_o
);
  import htb_pkg::*;

  logic                  is_sep;
  logic                  is_prefix;
  logic                  count_full;
  logic [4:0]            hi_dig;
  logic [4:0]            lo_dig;
  logic                  have_byte;
  logic [CHAR_BITS-1:0]  byte_out;
  dec_state_t            nxt;

  function automatic logic [4:0] digit_val(input logic [CHAR_BITS-1:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 5'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      v = 5'(c - CH_LOW_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = 5'(c - CH_UP_A + 8'd10);
    end
    return v;
  endfunction

  always_comb begin
    is_sep     = (char_i inside {CH_SPACE, [CH_TAB:CH_CR], CH_COLON, CH_COMMA});
    is_prefix  = (state_i.pending_char == CH_ZERO) && (char_i inside {CH_LOW_X, CH_UP_X});
    // full at the byte limit, or at the counter ceiling when the counter is narrow
    count_full = (32'(state_i.bytes_done) >= 32'(byte_limit_i)) || (&state_i.bytes_done);
    hi_dig     = digit_val(state_i.pending_char);
    lo_dig     = digit_val(char_i);
    have_byte  = 1'b0;
    byte_out   = '0;
    nxt        = state_i;

    if (!state_i.stopped) begin
      if (char_i == CH_NUL) begin
        if (state_i.pending_valid) begin
          nxt.error_code = ST_INCOMPLETE;
        end
        nxt.pending_valid = 1'b0;
        nxt.stopped       = 1'b1;
      end else if (!state_i.pending_valid) begin
        if (!is_sep) begin
          nxt.pending_char  = char_i;
          nxt.pending_valid = 1'b1;
        end
      end else begin
        nxt.pending_valid = 1'b0;
        if (is_prefix) begin
          // drop the 0x prefix
        end else if (count_full) begin
          nxt.error_code = ST_NO_ROOM;
          nxt.stopped    = 1'b1;
        end else if (hi_dig[4] || lo_dig[4]) begin
          nxt.error_code = ST_BAD_FORMAT;
          nxt.stopped    = 1'b1;
        end else begin
          byte_out       = {hi_dig[3:0], lo_dig[3:0]};
          nxt.bytes_done = state_i.bytes_done + COUNT_BITS'(1);
          have_byte      = 1'b1;
        end
      end
    end

    if (last_i && !nxt.stopped && nxt.pending_valid) begin
      nxt.error_code    = ST_INCOMPLETE;
      nxt.pending_valid = 1'b0;
      nxt.stopped       = 1'b1;
    end

    emit_o              = have_byte || last_i;
    result_o.byte_value = byte_out;
    result_o.byte_valid = have_byte;
    result_o.done_res   = last_i;
    result_o.status     = last_i ? nxt.error_code : ST_OK;
    result_o.byte_total = TOTAL_BITS'(32'(nxt.bytes_done));

    state_o = last_i ? STATE_RESET : nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/hex_text_to_bytes_core.sv =====
// Top level of the hex text to bytes decoder: stream ports, register port, pipeline.
`default_nettype none

// Decodes hex text, one character per input word, into bytes. Separators
// (C whitespace, colon, comma) between pairs are skipped and a 0x/0X prefix
// is dropped. Each decoded byte gives one output word; the word with tlast
// on the input gives the final word (tlast set) carrying the status and the
// byte count, and clears the per-string state. The first error stops
// decoding until the end of the string. One character is taken every cycle:
// a word passes an input register, the combinational decode logic and an output
// register, where its result is presented until it is taken, and back pressure
// only stalls the input when a result word is waiting.
// The byte limit sits at byte address 0 and may be written only while idle.
module hex_text_to_bytes_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  logic        s_tlast_i,   // last_char
  // master side
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [7:0] byte_value, [23:8] byte_total
  output logic [2:0]  m_tuser_o,   // [0] byte_valid, [2:1] status
  output logic        m_tlast_o,   // done_res
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import htb_pkg::*;

  logic [LIMIT_BITS-1:0] byte_limit_q;
  logic                  in_valid_q;
  logic [CHAR_BITS-1:0]  in_char_q;
  logic                  in_last_q;
  dec_state_t            state_q;
  dec_state_t            state_d;
  logic                  out_valid_q;
  dec_result_t           out_q;
  dec_result_t           result;
  logic                  emit;
  logic                  advance;
  logic                  take_in;
  logic                  reg_sel;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[2] == REG_BYTE_LIMIT);
  assign prdata_o = reg_sel ? 32'(byte_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= '1;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      byte_limit_q <= pwdata_i[LIMIT_BITS-1:0];
    end
  end

  htb_step u_step (
    .state_i      (state_q),
    .char_i       (in_char_q),
    .last_i       (in_last_q),
    .byte_limit_i (byte_limit_q),
    .state_o      (state_d),
    .result_o     (result),
    .emit_o       (emit)
  );

  // advance when the result slot is free or being taken, or the word makes no result
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i || !emit);
  assign s_tready_o = !in_valid_q || advance;
  assign take_in    = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_char_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_q.byte_total, out_q.byte_value};
  assign m_tuser_o  = {out_q.status, out_q.byte_valid};
  assign m_tlast_o  = out_q.done_res;

endmodule

`default_nettype wire
